// ===== rtl/core/jse_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON string escaper package
// Shared constants, the escape sequence type and the hex digit helper.
// ----------------------------------------------------------------------------
package jse_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int CAP_BITS       = 16;
  localparam int SEQ_MAX        = 7;
  localparam int ESC_MAX        = 6;
  localparam int LEN_BITS       = 3;
  localparam int CAP_MARGIN     = 8;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 16'd512;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [7:0] QUOTE_CH  = 8'h22;
  localparam logic [7:0] BSLASH_CH = 8'h5c;
  localparam logic [7:0] LF_CH     = 8'h0a;
  localparam logic [7:0] CR_CH     = 8'h0d;
  localparam logic [7:0] TAB_CH    = 8'h09;
  localparam logic [7:0] N_CH      = 8'h6e;
  localparam logic [7:0] R_CH      = 8'h72;
  localparam logic [7:0] T_CH      = 8'h74;
  localparam logic [7:0] U_CH      = 8'h75;
  localparam logic [7:0] ZERO_CH   = 8'h30;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  typedef struct packed {
    logic [SEQ_MAX-1:0][7:0] data;
    logic [LEN_BITS-1:0]     len;
    logic                    last;
  } seq_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'h0, v};
    end else begin
      r = 8'h61 + {4'h0, v} - 8'd10;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/jse_if.sv =====
// ----------------------------------------------------------------------------
// JSON string escaper channels
// Valid/ready channels for source items, escaped bytes and the capacity write.
// ----------------------------------------------------------------------------
interface jse_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_byte;
  modport source (output valid, output kind, output in_byte, input ready);
  modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

interface jse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

interface jse_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_capacity;
  modport source (output valid, output out_capacity, input ready);
  modport sink   (input valid, input out_capacity, output ready);
endinterface

// ===== rtl/core/json_string_escaper.sv =====
// ----------------------------------------------------------------------------
// JSON string escaper
// Streams string bytes out as one quoted, escaped JSON string.
// ----------------------------------------------------------------------------
//   channel | dir | payload                 | request
//   in_i    | in  | kind, in_byte           | one source byte or end of string
//   out_o   | out | out_byte, last          | one escaped output byte
//   cfg_i   | in  | out_capacity            | destination capacity write
//
// One output byte per cycle while out_o is ready; a request expands to zero
// to seven bytes, one for a plain byte and seven for a unicode escape with
// opening quote. The sequence buffer in the emitter sets the rate: a new
// request is taken in the cycle its last byte leaves. Stalls on out_o hold the buffer.
// Reset closes the string, clears the count and sets capacity to 512.
// ----------------------------------------------------------------------------
module json_string_escaper #(
  parameter int COUNT_BITS = jse_pkg::COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  jse_in_if.sink     in_i,
  jse_out_if.source  out_o,
  jse_cfg_if.sink    cfg_i
);
  import jse_pkg::*;

  seq_t seq;
  logic free;
  logic take;

  assign in_i.ready  = free;
  assign take        = in_i.valid && free;
  assign cfg_i.ready = 1'b1;

  jse_expand #(
    .COUNT_BITS (COUNT_BITS)
  ) u_expand (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .kind_i    (in_i.kind),
    .in_byte_i (in_i.in_byte),
    .cfg_we_i  (cfg_i.valid),
    .cfg_cap_i (cfg_i.out_capacity),
    .seq_o     (seq)
  );

  jse_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .seq_i      (seq),
    .free_o     (free),
    .valid_o    (out_o.valid),
    .ready_i    (out_o.ready),
    .out_byte_o (out_o.out_byte),
    .last_o     (out_o.last)
  );

endmodule

// ===== rtl/core/jse_expand.sv =====
// ----------------------------------------------------------------------------
// JSON string escaper expander
// Holds string state and capacity; maps one request to its escape sequence.
// ----------------------------------------------------------------------------
module jse_expand #(
  parameter int COUNT_BITS = jse_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          take_i,
  input  logic                          kind_i,
  input  logic [7:0]                    in_byte_i,
  input  logic                          cfg_we_i,
  input  logic [jse_pkg::CAP_BITS-1:0]  cfg_cap_i,
  output jse_pkg::seq_t                 seq_o
);
  import jse_pkg::*;

  localparam int CW = ((COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS) + 1;

  logic [CAP_BITS-1:0]   cap_q;
  logic                  open_q, open_d;
  logic [COUNT_BITS-1:0] count_q, count_d;

  logic [COUNT_BITS-1:0] base;
  logic                  fits;
  logic [7:0]            second;
  logic                  two;
  logic [ESC_MAX-1:0][7:0] esc;
  logic [LEN_BITS-1:0]   elen;
  logic                  elast;

  assign base = open_q ? count_q : COUNT_BITS'(1);
  assign fits = (CW'(base) + CW'(CAP_MARGIN)) < CW'(cap_q);

  always_comb begin
    two    = 1'b1;
    second = QUOTE_CH;
    case (in_byte_i)
      QUOTE_CH:  second = QUOTE_CH;
      BSLASH_CH: second = BSLASH_CH;
      LF_CH:     second = N_CH;
      CR_CH:     second = R_CH;
      TAB_CH:    second = T_CH;
      default:   two = 1'b0;
    endcase
  end

  always_comb begin
    esc   = '0;
    elen  = '0;
    elast = 1'b0;
    if (kind_i == KIND_END) begin
      esc[0] = QUOTE_CH;
      elen   = LEN_BITS'(1);
      elast  = 1'b1;
    end else if (!fits) begin
      elen = '0;
    end else if (two) begin
      esc[0] = BSLASH_CH;
      esc[1] = second;
      elen   = LEN_BITS'(2);
    end else if (in_byte_i < CTRL_LIMIT) begin
      esc[0] = BSLASH_CH;
      esc[1] = U_CH;
      esc[2] = ZERO_CH;
      esc[3] = ZERO_CH;
      esc[4] = hex_digit(in_byte_i[7:4]);
      esc[5] = hex_digit(in_byte_i[3:0]);
      elen   = LEN_BITS'(6);
    end else begin
      esc[0] = in_byte_i;
      elen   = LEN_BITS'(1);
    end
  end

  always_comb begin
    seq_o      = '0;
    seq_o.last = elast;
    if (!open_q) begin
      seq_o.data[0] = QUOTE_CH;
      for (int k = 0; k < ESC_MAX; k++) begin
        seq_o.data[k+1] = esc[k];
      end
      seq_o.len = elen + LEN_BITS'(1);
    end else begin
      for (int k = 0; k < ESC_MAX; k++) begin
        seq_o.data[k] = esc[k];
      end
      seq_o.len = elen;
    end
  end

  always_comb begin
    open_d  = open_q;
    count_d = count_q;
    if (take_i) begin
      if (kind_i == KIND_END) begin
        open_d  = 1'b0;
        count_d = '0;
      end else begin
        open_d  = 1'b1;
        count_d = base + COUNT_BITS'(elen);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      count_q <= '0;
      cap_q   <= CAP_RESET;
    end else begin
      open_q  <= open_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_cap_i;
      end
    end
  end

endmodule

// ===== rtl/core/jse_emit.sv =====
// ----------------------------------------------------------------------------
// JSON string escaper emitter
// Buffers one escape sequence and hands it out one byte per cycle while ready_i is high.
// ----------------------------------------------------------------------------
module jse_emit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  jse_pkg::seq_t seq_i,
  output logic          free_o,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [7:0]    out_byte_o,
  output logic          last_o
);
  import jse_pkg::*;

  seq_t                seq_q, seq_d;
  logic                busy_q, busy_d;
  logic [LEN_BITS-1:0] idx_q, idx_d;
  logic                at_end;
  logic                done;

  assign at_end     = (idx_q == (seq_q.len - LEN_BITS'(1)));
  assign done       = busy_q && ready_i && at_end;
  assign free_o     = !busy_q || done;
  assign valid_o    = busy_q;
  assign out_byte_o = seq_q.data[idx_q];
  assign last_o     = seq_q.last && at_end;

  always_comb begin
    seq_d  = seq_q;
    busy_d = busy_q;
    idx_d  = idx_q;
    if (take_i) begin
      seq_d  = seq_i;
      busy_d = (seq_i.len != '0);
      idx_d  = '0;
    end else if (busy_q && ready_i) begin
      if (at_end) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + LEN_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q <= seq_d;
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON string escaper testbench
// Drives source bytes and end markers through random gaps and checks every
// quoted, escaped output byte and its last flag against an in-bench predictor
// of the escaping and capacity logic, across several capacity settings.
// ----------------------------------------------------------------------------
module testbench;
  import jse_pkg::*;

  localparam int          IDLE_LIMIT = 3000;
  localparam int          HOLD_CYCLES = 300;
  localparam logic [7:0]  HEX_A_CH   = 8'h61;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } src_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } quoted_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  jse_in_if  in_if();
  jse_out_if out_if();
  jse_cfg_if cfg_if();

  json_string_escaper u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  src_item_t   src_q[$];
  quoted_t     quoted_q[$];
  logic        str_open = 1'b0;
  logic [15:0] out_cnt  = 16'd0;
  logic [15:0] cap_reg  = CAP_RESET;
  int          err_cnt  = 0;
  int          src_gap  = 0;
  int          snk_gap  = 0;
  int          idle_cyc = 0;
  bit          calm     = 1'b0;
  bit          stall_req = 1'b0;
  logic        sink_blocked = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void want_byte(input logic [7:0] b, input logic last);
    quoted_q.push_back('{data: b, last: last});
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? ZERO_CH + 8'(nib) : HEX_A_CH + 8'(nib) - 8'd10;
  endfunction

  function automatic void escape_item(input logic kind, input logic [7:0] c);
    logic [7:0] second;
    if (!str_open) begin
      want_byte(QUOTE_CH, 1'b0);
      str_open = 1'b1;
      out_cnt  = 16'd1;
    end
    if (kind == KIND_END) begin
      want_byte(QUOTE_CH, 1'b1);
      str_open = 1'b0;
      out_cnt  = 16'd0;
    end else if (int'(out_cnt) + CAP_MARGIN < int'(cap_reg)) begin
      second = 8'h00;
      case (c)
        QUOTE_CH:  second = QUOTE_CH;
        BSLASH_CH: second = BSLASH_CH;
        LF_CH:     second = N_CH;
        CR_CH:     second = R_CH;
        TAB_CH:    second = T_CH;
        default:   second = 8'h00;
      endcase
      if (second != 8'h00) begin
        want_byte(BSLASH_CH, 1'b0);
        want_byte(second, 1'b0);
        out_cnt = out_cnt + 16'd2;
      end else if (c < CTRL_LIMIT) begin
        want_byte(BSLASH_CH, 1'b0);
        want_byte(U_CH, 1'b0);
        want_byte(ZERO_CH, 1'b0);
        want_byte(ZERO_CH, 1'b0);
        want_byte(hex_char(c[7:4]), 1'b0);
        want_byte(hex_char(c[3:0]), 1'b0);
        out_cnt = out_cnt + 16'd6;
      end else begin
        want_byte(c, 1'b0);
        out_cnt = out_cnt + 16'd1;
      end
    end
  endfunction

  function automatic void check_byte(input logic [7:0] b, input logic last);
    quoted_t w;
    if (quoted_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 10) $display("unexpected output byte %h last %b", b, last);
    end else begin
      w = quoted_q.pop_front();
      if (b !== w.data || last !== w.last) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("mismatch: expected byte %h last %b, got byte %h last %b",
                   w.data, w.last, b, last);
      end
    end
  endfunction

  function automatic void add_byte(input logic [7:0] c);
    src_q.push_back('{kind: KIND_BYTE, data: c});
  endfunction

  function automatic void add_end();
    src_q.push_back('{kind: KIND_END, data: 8'($urandom_range(0, 255))});
  endfunction

  function automatic logic [7:0] draw_char();
    logic [7:0]  specials [8];
    int unsigned pick;
    specials = '{QUOTE_CH, BSLASH_CH, LF_CH, CR_CH, TAB_CH, 8'h00, 8'h1f, 8'h7f};
    pick = $urandom_range(0, 9);
    if (pick < 3) return specials[$urandom_range(0, 7)];
    else if (pick < 7) return 8'($urandom_range(32, 126));
    else return 8'($urandom_range(0, 255));
  endfunction

  task automatic drain();
    while (src_q.size() != 0 || in_if.valid || quoted_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [15:0] v);
    drain();
    @(posedge clk_i);
    cfg_if.valid        <= 1'b1;
    cfg_if.out_capacity <= v;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    cap_reg = v;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.kind    <= KIND_BYTE;
      in_if.in_byte <= 8'h00;
      src_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        escape_item(in_if.kind, in_if.in_byte);
        void'(src_q.pop_front());
        src_gap = calm ? 0 : $urandom_range(0, 4);
      end
      if (!in_if.valid || in_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_if.valid <= 1'b0;
        end else if (src_q.size() != 0) begin
          in_if.valid   <= 1'b1;
          in_if.kind    <= src_q[0].kind;
          in_if.in_byte <= src_q[0].data;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        check_byte(out_if.out_byte, out_if.last);
        snk_gap = calm ? 0 : $urandom_range(0, 4);
      end
      if (sink_blocked) begin
        out_if.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // hold off the output for a long stretch while requests keep coming
  initial begin
    wait (stall_req);
    @(posedge clk_i);
    sink_blocked <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    sink_blocked <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cyc <= 0;
      end else if (idle_cyc + 1 >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cyc <= idle_cyc + 1;
      end
    end
  end

  initial begin
    logic [15:0] caps [9];
    logic [7:0]  dir_bytes [13];
    int unsigned count;
    int unsigned len;
    caps = '{16'hffff, 16'd16, 16'd40, 16'd3, CAP_RESET, 16'd9, 16'd200, 16'd24, 16'd0};
    dir_bytes = '{8'h00, 8'h1f, QUOTE_CH, BSLASH_CH, LF_CH, CR_CH, TAB_CH,
                  8'h7f, 8'h80, 8'hff, 8'h20, 8'h41, 8'h1b};
    in_if.valid         = 1'b0;
    in_if.kind          = KIND_BYTE;
    in_if.in_byte       = 8'h00;
    out_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.out_capacity = 16'd0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_end();
    foreach (dir_bytes[i]) add_byte(dir_bytes[i]);
    add_end();
    write_capacity(16'd3);
    add_byte(8'h41);
    add_end();
    write_capacity(16'd9);
    add_byte(8'h41);
    add_end();
    write_capacity(16'd10);
    add_byte(8'h41);
    add_byte(8'h42);
    write_capacity(CAP_RESET);
    add_byte(8'h43);
    add_end();

    for (int p = 0; p < 9; p++) begin
      calm = (p % 3 == 2);
      write_capacity(p == 8 ? 16'($urandom_range(3, 64)) : caps[p]);
      if (p == 0) stall_req = 1'b1;
      count = 0;
      while (count < 38) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        for (int k = 0; k < len; k++) add_byte(draw_char());
        add_end();
        count += len + 1;
      end
      if (p % 2 == 1) repeat ($urandom_range(1, 3)) add_byte(draw_char());
    end

    drain();
    repeat (20) @(negedge clk_i);
    if (err_cnt == 0 && quoted_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
